[rtl/i2cram_pkg.sv]
// Types, constants and step decode for the I2C register access master.
package i2cram_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    SEG_START,
    SEG_SEND,
    SEG_STOP,
    SEG_RD_ACK,
    SEG_RD_NACK
  } seg_kind_e;

  typedef enum logic [2:0] {
    SRC_ADDR,
    SRC_ADDR1,
    SRC_REG,
    SRC_HI,
    SRC_LO
  } src_e;

  localparam int unsigned StartLen = 4;
  localparam int unsigned SendLen  = 28;
  localparam int unsigned StopLen  = 3;
  localparam int unsigned RdLen    = 20;

  localparam int unsigned WrRegBase   = StartLen + SendLen;
  localparam int unsigned WrHiBase    = WrRegBase + SendLen;
  localparam int unsigned WrLoBase    = WrHiBase + SendLen;
  localparam int unsigned WrStopBase  = WrLoBase + SendLen;
  localparam int unsigned WriteSteps  = WrStopBase + StopLen;

  localparam int unsigned RdStop0Base  = StartLen + 2 * SendLen;
  localparam int unsigned RdStart1Base = RdStop0Base + StopLen;
  localparam int unsigned RdAddr1Base  = RdStart1Base + StartLen;
  localparam int unsigned RdAckBase    = RdAddr1Base + SendLen;
  localparam int unsigned RdNackBase   = RdAckBase + RdLen;
  localparam int unsigned RdStop1Base  = RdNackBase + RdLen;
  localparam int unsigned ReadSteps    = RdStop1Base + StopLen;

  localparam logic [7:0] AddrReset = 8'h40;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  register_pointer;
    logic [15:0] write_value;
    logic        sda_sample;
  } in_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        read_valid;
    logic [15:0] read_data;
  } out_t;

  typedef struct packed {
    seg_kind_e  kind;
    src_e       src;
    logic [4:0] offset;
  } seg_t;

  function automatic seg_t seg_at(seg_kind_e kind, src_e src, logic [7:0] step,
                                  int unsigned base);
    seg_t s;
    s.kind   = kind;
    s.src    = src;
    s.offset = 5'(step - 8'(base));
    return s;
  endfunction

  function automatic seg_t decode_step(logic rd, logic [7:0] step);
    seg_t s;
    if (!rd) begin
      if (step < 8'(StartLen))        s = seg_at(SEG_START, SRC_ADDR, step, 0);
      else if (step < 8'(WrRegBase))  s = seg_at(SEG_SEND, SRC_ADDR, step, StartLen);
      else if (step < 8'(WrHiBase))   s = seg_at(SEG_SEND, SRC_REG, step, WrRegBase);
      else if (step < 8'(WrLoBase))   s = seg_at(SEG_SEND, SRC_HI, step, WrHiBase);
      else if (step < 8'(WrStopBase)) s = seg_at(SEG_SEND, SRC_LO, step, WrLoBase);
      else                            s = seg_at(SEG_STOP, SRC_ADDR, step, WrStopBase);
    end else begin
      if (step < 8'(StartLen))          s = seg_at(SEG_START, SRC_ADDR, step, 0);
      else if (step < 8'(WrRegBase))    s = seg_at(SEG_SEND, SRC_ADDR, step, StartLen);
      else if (step < 8'(RdStop0Base))  s = seg_at(SEG_SEND, SRC_REG, step, WrRegBase);
      else if (step < 8'(RdStart1Base)) s = seg_at(SEG_STOP, SRC_ADDR, step, RdStop0Base);
      else if (step < 8'(RdAddr1Base))  s = seg_at(SEG_START, SRC_ADDR, step, RdStart1Base);
      else if (step < 8'(RdAckBase))    s = seg_at(SEG_SEND, SRC_ADDR1, step, RdAddr1Base);
      else if (step < 8'(RdNackBase))   s = seg_at(SEG_RD_ACK, SRC_ADDR, step, RdAckBase);
      else if (step < 8'(RdStop1Base))  s = seg_at(SEG_RD_NACK, SRC_ADDR, step, RdNackBase);
      else                              s = seg_at(SEG_STOP, SRC_ADDR, step, RdStop1Base);
    end
    return s;
  endfunction

  // bit number within a sent byte for offsets 1..24 (three steps per bit)
  function automatic logic [2:0] send_bit_index(logic [4:0] o);
    logic [2:0] k;
    k = 3'd0;
    for (int j = 1; j < 8; j++) begin
      if (o >= 5'(3 * j + 1)) k = 3'(j);
    end
    return k;
  endfunction

endpackage

[rtl/i2c_register_access_master_unit.sv]
// I2C master that sequences 16-bit register writes and reads one pin step per item.
//
// Usage: each input item on in_valid_i/in_ready_o is one bus half-period tick.
// An item whose op is write or read while the block is idle latches the register
// pointer and write value and performs the first pin step on that same tick; op
// values while busy are ignored. Every accepted item yields exactly one result
// item on out_valid_o/out_ready_i with the SCL/SDA levels to drive, the busy flag,
// and on the last step of a read a one-tick read_valid with the 16-bit data.
// A write takes 119 items, a read 138 items.
// Latency: the result for an item is presented the cycle after it is accepted.
// Throughput: one item per cycle unless the receiver stalls; the step counter, a
// combinational step decode to segment and offset, and the result register set it.
// The result register frees up in the cycle it is taken, so a new item is
// accepted while the previous result is being taken. While the receiver stalls,
// the held result stays and no new item is accepted.
// Reset: bus idle (both lines released), no transaction, address byte 0x40,
// output empty. cfg_we_i writes the address byte at once.
module i2c_register_access_master_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2cram_pkg::in_t   in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2cram_pkg::out_t  out_item_o
);
  import i2cram_pkg::*;

  logic [7:0]  addr_q;
  logic [7:0]  step_q, step_d;
  logic        is_read_q, is_read_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] val_q, val_d;
  logic [15:0] shift_q, shift_d;
  logic [1:0]  pin_q, pin_d;
  logic        out_valid_q;
  out_t        out_q, out_d;

  logic        in_fire;
  logic        start;
  logic        active;
  logic [7:0]  step_nxt;
  logic [7:0]  total;
  seg_t        seg;
  logic [7:0]  src_byte;
  logic [2:0]  bit_k;
  logic [4:0]  bit_rem;
  logic [4:0]  rd_off;
  logic        ack_bit;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    step_d    = step_q;
    is_read_d = is_read_q;
    reg_d     = reg_q;
    val_d     = val_q;
    shift_d   = shift_q;
    pin_d     = pin_q;
    out_d     = '0;

    start = (step_q == 8'd0) &&
            (in_item_i.op == OP_WRITE || in_item_i.op == OP_READ);
    if (start) begin
      is_read_d = (in_item_i.op == OP_READ);
      reg_d     = in_item_i.register_pointer;
      val_d     = in_item_i.write_value;
      shift_d   = '0;
    end
    active = (step_q != 8'd0) || start;

    seg = decode_step(is_read_d, step_q);
    case (seg.src)
      SRC_ADDR1: src_byte = addr_q + 8'd1;
      SRC_REG:   src_byte = reg_d;
      SRC_HI:    src_byte = val_d[15:8];
      SRC_LO:    src_byte = val_d[7:0];
      default:   src_byte = addr_q;
    endcase
    bit_k   = send_bit_index(seg.offset);
    bit_rem = seg.offset - 5'd1 - 5'(3 * bit_k);
    rd_off  = seg.offset - 5'd16;
    ack_bit = (seg.kind == SEG_RD_NACK);
    total   = is_read_d ? 8'(ReadSteps) : 8'(WriteSteps);
    step_nxt = step_q + 8'd1;

    if (active) begin
      case (seg.kind)
        SEG_START: begin
          case (seg.offset)
            5'd0:    pin_d[0] = 1'b1;
            5'd1:    pin_d[1] = 1'b1;
            5'd2:    pin_d[0] = 1'b0;
            default: pin_d[1] = 1'b0;
          endcase
        end
        SEG_SEND: begin
          if (seg.offset == 5'd0) begin
            pin_d[1] = 1'b0;
          end else if (seg.offset <= 5'd24) begin
            if (bit_rem == 5'd0) pin_d[0] = src_byte[3'd7 - bit_k];
            else                 pin_d[1] = (bit_rem == 5'd1);
          end else if (seg.offset == 5'd25) begin
            pin_d[0] = 1'b1;
          end else begin
            pin_d[1] = (seg.offset == 5'd26);
          end
        end
        SEG_STOP: begin
          case (seg.offset)
            5'd0:    pin_d[0] = 1'b0;
            5'd1:    pin_d[1] = 1'b1;
            default: pin_d[0] = 1'b1;
          endcase
        end
        default: begin
          if (seg.offset < 5'd16) begin
            if (!seg.offset[0]) begin
              pin_d[1] = 1'b1;
            end else begin
              shift_d  = {shift_d[14:0], in_item_i.sda_sample};
              pin_d[1] = 1'b0;
            end
          end else begin
            case (rd_off)
              5'd0:    pin_d[0] = ack_bit;
              5'd1:    pin_d[1] = 1'b1;
              5'd2:    pin_d[1] = 1'b0;
              default: pin_d[0] = !ack_bit;
            endcase
          end
        end
      endcase

      if (step_nxt >= total) begin
        step_d = 8'd0;
        if (is_read_d) begin
          out_d.read_valid = 1'b1;
          out_d.read_data  = shift_d;
        end
      end else begin
        step_d = step_nxt;
      end
    end

    out_d.scl_level = pin_d[1];
    out_d.sda_level = pin_d[0];
    out_d.busy_res  = (step_d != 8'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= AddrReset;
    end else if (cfg_we_i) begin
      addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      is_read_q <= 1'b0;
      reg_q     <= '0;
      val_q     <= '0;
      shift_q   <= '0;
      pin_q     <= 2'b11;
    end else if (in_fire) begin
      step_q    <= step_d;
      is_read_q <= is_read_d;
      reg_q     <= reg_d;
      val_q     <= val_d;
      shift_q   <= shift_d;
      pin_q     <= pin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q < 8'(ReadSteps)) && (is_read_q || step_q < 8'(WriteSteps)))
    else $error("step counter out of range");

  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && step_q != 8'd0 |=> step_q == 8'd0 || step_q == $past(step_q) + 8'd1)
    else $error("step counter skipped");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.read_valid |-> !out_q.busy_res && is_read_q)
    else $error("read completion while still busy");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.read_valid |-> out_q.read_data == 16'd0)
    else $error("read data without completion");

  a_busy_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_q.busy_res == (step_q != 8'd0))
    else $error("busy flag disagrees with step counter");

endmodule

[tb/tb_top.sv]
// Testbench for the I2C register access master: tick stimulus, pin prediction, result checks.
module tb_top;
  import i2cram_pkg::*;

  typedef enum {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_e;

  localparam logic [1:0] OpUndefined = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_item_o;

  logic [7:0] dev_addr = AddrReset;
  logic [7:0] bus_pos = '0;
  logic bus_is_read = 1'b0;
  logic [7:0] bus_ptr = '0;
  logic [15:0] bus_value = '0;
  logic [15:0] bus_shift = '0;
  logic bus_scl = 1'b1;
  logic bus_sda = 1'b1;

  out_t predicted_bus_q[$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned writes_started = 0;
  int unsigned reads_started = 0;
  int unsigned reads_done = 0;
  int unsigned addresses_used = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  i2c_register_access_master_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic out_t predict_bus_step(in_t it);
    out_t r;
    seg_kind_e kind;
    int unsigned pos, o, total;
    logic [7:0] tx_byte;
    logic active, ackbit;
    r = '0;
    kind = SEG_START;
    o = 0;
    tx_byte = dev_addr;
    active = (bus_pos != 0);
    if (!active && (it.op == OP_WRITE || it.op == OP_READ)) begin
      bus_is_read = (it.op == OP_READ);
      bus_ptr = it.register_pointer;
      bus_value = it.write_value;
      bus_shift = '0;
      active = 1'b1;
      if (bus_is_read) reads_started++;
      else writes_started++;
    end
    if (active) begin
      pos = bus_pos;
      if (!bus_is_read) begin
        if (pos < StartLen) begin
          o = pos;
        end else if (pos < WrStopBase) begin
          kind = SEG_SEND;
          o = (pos - StartLen) % SendLen;
          case ((pos - StartLen) / SendLen)
            0: tx_byte = dev_addr;
            1: tx_byte = bus_ptr;
            2: tx_byte = bus_value[15:8];
            default: tx_byte = bus_value[7:0];
          endcase
        end else begin
          kind = SEG_STOP;
          o = pos - WrStopBase;
        end
      end else begin
        if (pos < StartLen) begin
          o = pos;
        end else if (pos < RdStop0Base) begin
          kind = SEG_SEND;
          o = (pos - StartLen) % SendLen;
          tx_byte = (pos < WrRegBase) ? dev_addr : bus_ptr;
        end else if (pos < RdStart1Base) begin
          kind = SEG_STOP;
          o = pos - RdStop0Base;
        end else if (pos < RdAddr1Base) begin
          o = pos - RdStart1Base;
        end else if (pos < RdAckBase) begin
          kind = SEG_SEND;
          o = pos - RdAddr1Base;
          tx_byte = dev_addr + 8'd1;
        end else if (pos < RdNackBase) begin
          kind = SEG_RD_ACK;
          o = pos - RdAckBase;
        end else if (pos < RdStop1Base) begin
          kind = SEG_RD_NACK;
          o = pos - RdNackBase;
        end else begin
          kind = SEG_STOP;
          o = pos - RdStop1Base;
        end
      end

      case (kind)
        SEG_START: begin
          case (o)
            0: bus_sda = 1'b1;
            1: bus_scl = 1'b1;
            2: bus_sda = 1'b0;
            default: bus_scl = 1'b0;
          endcase
        end
        SEG_SEND: begin
          if (o == 0) begin
            bus_scl = 1'b0;
          end else if (o <= 24) begin
            case ((o - 1) % 3)
              0: bus_sda = tx_byte[7 - (o - 1) / 3];
              1: bus_scl = 1'b1;
              default: bus_scl = 1'b0;
            endcase
          end else if (o == 25) begin
            bus_sda = 1'b1;
          end else begin
            bus_scl = (o == 26);
          end
        end
        SEG_STOP: begin
          case (o)
            0: bus_sda = 1'b0;
            1: bus_scl = 1'b1;
            default: bus_sda = 1'b1;
          endcase
        end
        default: begin
          ackbit = (kind == SEG_RD_NACK);
          if (o < 16) begin
            if (o % 2 == 0) begin
              bus_scl = 1'b1;
            end else begin
              bus_shift = {bus_shift[14:0], it.sda_sample};
              bus_scl = 1'b0;
            end
          end else begin
            case (o - 16)
              0: bus_sda = ackbit;
              1: bus_scl = 1'b1;
              2: bus_scl = 1'b0;
              default: bus_sda = !ackbit;
            endcase
          end
        end
      endcase

      total = bus_is_read ? ReadSteps : WriteSteps;
      pos++;
      if (pos >= total) begin
        bus_pos = '0;
        if (bus_is_read) begin
          r.read_valid = 1'b1;
          r.read_data = bus_shift;
          reads_done++;
        end
      end else begin
        bus_pos = 8'(pos);
      end
    end
    r.scl_level = bus_scl;
    r.sda_level = bus_sda;
    r.busy_res = (bus_pos != 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d %s: want %h got %h", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_bus_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing pending: %h", results_seen, out_item_o);
      end else begin
        want = predicted_bus_q.pop_front();
        check_field("scl_level", 16'(want.scl_level), 16'(out_item_o.scl_level));
        check_field("sda_level", 16'(want.sda_level), 16'(out_item_o.sda_level));
        check_field("busy_res", 16'(want.busy_res), 16'(out_item_o.busy_res));
        check_field("read_valid", 16'(want.read_valid), 16'(out_item_o.read_valid));
        check_field("read_data", want.read_data, out_item_o.read_data);
      end
      results_seen++;
    end
  end

  initial begin
    int unsigned stall;
    @(posedge clk_i iff rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_tick(in_t it);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_bus_q.push_back(predict_bus_step(it));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_bus_q.size() != 0);
  endtask

  function automatic logic pick_sda(sda_mode_e m);
    case (m)
      SDA_LOW: return 1'b0;
      SDA_HIGH: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic in_t random_tick(bit noisy);
    in_t it;
    it.op = noisy ? 2'($urandom_range(0, 3)) : OP_TICK;
    it.register_pointer = 8'($urandom_range(0, 255));
    it.write_value = 16'($urandom_range(0, 65535));
    it.sda_sample = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic run_transaction(logic [1:0] op, logic [7:0] ptr, logic [15:0] value,
                                 sda_mode_e mode, bit noisy);
    in_t it;
    it.op = op;
    it.register_pointer = ptr;
    it.write_value = value;
    it.sda_sample = pick_sda(mode);
    send_tick(it);
    while (bus_pos != 0) begin
      it = random_tick(noisy);
      it.sda_sample = pick_sda(mode);
      send_tick(it);
    end
  endtask

  task automatic set_device_address(logic [7:0] a);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dev_addr = a;
    addresses_used++;
  endtask

  task automatic test_idle_ticks();
    in_t it;
    it = '0;
    it.op = OP_TICK;
    send_tick(it);
    it = '1;
    it.op = OpUndefined;
    send_tick(it);
    it.op = OP_TICK;
    send_tick(it);
  endtask

  task automatic test_write_extremes();
    run_transaction(OP_WRITE, 8'h00, 16'h0000, SDA_LOW, 1'b0);
    run_transaction(OP_WRITE, 8'hFF, 16'hFFFF, SDA_HIGH, 1'b1);
  endtask

  task automatic test_read_extremes();
    run_transaction(OP_READ, 8'hFF, 16'hFFFF, SDA_HIGH, 1'b1);
  endtask

  task automatic test_address_extremes();
    set_device_address(8'h00);
    run_transaction(OP_WRITE, 8'hA5, 16'h5A3C, SDA_RANDOM, 1'b0);
    set_device_address(8'hFF);
    run_transaction(OP_READ, 8'h00, 16'h0000, SDA_LOW, 1'b1);
    set_device_address(AddrReset);
  endtask

  task automatic test_random_traffic();
    int unsigned target, next_phase;
    in_t it;
    target = 750;
    next_phase = items_sent + 60;
    set_device_address(8'($urandom_range(0, 255)));
    while (items_sent < target) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          it = random_tick(1'b0);
          it.op = $urandom_range(0, 1) ? OP_TICK : OpUndefined;
          send_tick(it);
        end
      end else begin
        run_transaction($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                        8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        SDA_RANDOM, $urandom_range(0, 3) == 0);
      end
      if (items_sent >= next_phase && items_sent < target) begin
        set_device_address(8'($urandom_range(0, 255)));
        next_phase = items_sent + 60;
      end
    end
  endtask

  initial begin
    int unsigned guard;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_ticks();
    test_write_extremes();
    test_read_extremes();
    test_address_extremes();
    test_random_traffic();

    in_valid_i <= 1'b0;
    guard = 0;
    while (predicted_bus_q.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (predicted_bus_q.size() != 0) begin
      mismatch_count += predicted_bus_q.size();
      $display("%0d results never arrived", predicted_bus_q.size());
    end

    $display("run covered %0d bus ticks: %0d writes, %0d reads started, %0d reads finished",
             items_sent, writes_started, reads_started, reads_done);
    $display("%0d device address changes, %0d results checked", addresses_used, results_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
